// ===== rtl/fh64bi_pkg.sv =====
// fh64bi_pkg: constants and types shared by the fasthash64 bucket index core
// no dependencies; every module of the core refers to it by scoped names
package fh64bi_pkg;

  localparam int unsigned HashW    = 64;
  localparam int unsigned LenBits  = 32;
  localparam int unsigned BcW      = 21;
  localparam int unsigned IdxW     = 20;
  localparam int unsigned CntW     = 4;
  localparam int unsigned HalfW    = HashW / 2;

  localparam logic [HashW-1:0] HashM       = 64'h8803_55f2_1e6d_1965;
  localparam logic [HashW-1:0] MixMul      = 64'h2127_599b_f432_5c37;
  localparam logic [HashW-1:0] SeedReset   = 64'd1469598103934665603;
  localparam logic [BcW-1:0]   BucketReset = 21'd1024;
  localparam logic [BcW-1:0]   BucketMax   = 21'd1048576;
  localparam int unsigned      MixShiftA   = 23;
  localparam int unsigned      MixShiftB   = 47;

  localparam int unsigned ModBitsPerStep = 2;
  localparam int unsigned ModSteps       = HashW / ModBitsPerStep;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    CFG_SEED     = 1'b0,
    CFG_NBUCKETS = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic               first;
    logic               last;
    logic               has_data;
    logic [LenBits-1:0] len;
    logic [HashW-1:0]   word;
  } q_entry_t;

  function automatic logic [HashW-1:0] pre_mix(input logic [HashW-1:0] x);
    pre_mix = x ^ (x >> MixShiftA);
  endfunction

  function automatic logic [HashW-1:0] post_mix(input logic [HashW-1:0] x);
    post_mix = x ^ (x >> MixShiftB);
  endfunction

endpackage

// ===== rtl/fh64bi_front.sv =====
// fh64bi_front: input side of the fasthash64 core; tracks key framing,
// masks the key word and holds the words of a key in a short queue for the back end
// depends on fh64bi_pkg
module fh64bi_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            first_word,
  input  logic [fh64bi_pkg::LenBits-1:0]  key_length,
  input  logic [fh64bi_pkg::HashW-1:0]    key_word,
  input  logic [fh64bi_pkg::CntW-1:0]     byte_count,
  input  logic                            last_word,
  output logic                            q_valid,
  output fh64bi_pkg::q_entry_t            q_head,
  input  logic                            q_pop
);

  localparam int unsigned PtrW = $clog2(fh64bi_pkg::QueueDepth);
  localparam int unsigned FillW = $clog2(fh64bi_pkg::QueueDepth + 1);
  localparam int unsigned Bytes = fh64bi_pkg::HashW / 8;

  fh64bi_pkg::q_entry_t mem_r [fh64bi_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FillW-1:0] fill_r, fill_nxt;
  logic             in_key_r, in_key_nxt;
  logic             accept;
  logic             push;
  logic             do_pop;
  logic [fh64bi_pkg::HashW-1:0] word_masked;
  fh64bi_pkg::q_entry_t new_entry;

  assign in_ready = (fill_r != FillW'(fh64bi_pkg::QueueDepth));
  assign accept   = in_valid & in_ready;
  assign push     = accept & (first_word | in_key_r);
  assign q_valid  = (fill_r != '0);
  assign do_pop   = q_pop & q_valid;
  assign q_head   = mem_r[rd_ptr_r];

  // byte lanes at or above the valid count read as zero
  always_comb begin
    for (int i = 0; i < Bytes; i++) begin
      if ((byte_count > fh64bi_pkg::CntW'(i)))
        word_masked[i*8 +: 8] = key_word[i*8 +: 8];
      else
        word_masked[i*8 +: 8] = 8'h00;
    end
  end

  always_comb begin
    new_entry.first    = first_word;
    new_entry.last     = last_word;
    new_entry.has_data = (byte_count != '0);
    new_entry.len      = key_length;
    new_entry.word     = word_masked;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    in_key_nxt = in_key_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(fh64bi_pkg::QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      in_key_nxt = ~last_word;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(fh64bi_pkg::QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
      in_key_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      in_key_r <= in_key_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

// ===== rtl/fh64bi_mul.sv =====
// fh64bi_mul: registered 64 x 64 multiplier keeping the low 64 bits of the product
// depends on fh64bi_pkg
module fh64bi_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fh64bi_pkg::HashW-1:0]  a,
  input  logic [fh64bi_pkg::HashW-1:0]  b,
  output logic                          done,
  output logic [fh64bi_pkg::HashW-1:0]  product
);

  localparam int unsigned H = fh64bi_pkg::HalfW;

  logic                          busy_r;
  logic                          done_r;
  logic [fh64bi_pkg::HashW-1:0]  p0_r;
  logic [H-1:0]                  cross_r;
  logic [H-1:0]                  a_hi_r;
  logic [H-1:0]                  b_lo_r;
  logic [fh64bi_pkg::HashW-1:0]  prod_r;
  logic [fh64bi_pkg::HashW-1:0]  pp_ll;
  logic [H-1:0]                  pp_lh;
  logic [H-1:0]                  pp_hl;
  logic [H-1:0]                  cross_sum;

  assign pp_ll     = a[H-1:0] * b[H-1:0];
  assign pp_lh     = a[H-1:0] * b[2*H-1:H];
  assign pp_hl     = a_hi_r * b_lo_r;
  assign cross_sum = cross_r + pp_hl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p0_r    <= pp_ll;
      cross_r <= pp_lh;
      a_hi_r  <= a[2*H-1:H];
      b_lo_r  <= b[H-1:0];
    end
    if (busy_r) begin
      prod_r <= p0_r + {cross_sum, {H{1'b0}}};
    end
  end

  assign done    = done_r;
  assign product = prod_r;

endmodule

// ===== rtl/fh64bi_mod.sv =====
// fh64bi_mod: iterative remainder of a 64-bit hash by a bucket count,
// fh64bi_pkg::ModBitsPerStep quotient bits per cycle; depends on fh64bi_pkg
module fh64bi_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [fh64bi_pkg::HashW-1:0]  dividend,
  input  logic [fh64bi_pkg::BcW-1:0]    divisor,
  output logic                          done,
  output logic [fh64bi_pkg::IdxW-1:0]   remainder
);

  localparam int unsigned StepW = $clog2(fh64bi_pkg::ModSteps);
  localparam int unsigned RemW  = fh64bi_pkg::BcW;

  logic                          busy_r;
  logic                          done_r;
  logic [StepW-1:0]              step_r;
  logic [RemW-1:0]               rem_r, rem_nxt;
  logic [fh64bi_pkg::HashW-1:0]  dvd_r, dvd_nxt;
  logic [RemW-1:0]               dsr_r;

  always_comb begin
    logic [RemW:0] t;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    for (int i = 0; i < fh64bi_pkg::ModBitsPerStep; i++) begin
      t = {rem_nxt, dvd_nxt[fh64bi_pkg::HashW-1]};
      dvd_nxt = {dvd_nxt[fh64bi_pkg::HashW-2:0], 1'b0};
      if (t >= {1'b0, dsr_r}) begin
        t = t - {1'b0, dsr_r};
      end
      rem_nxt = t[RemW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == StepW'(fh64bi_pkg::ModSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r[fh64bi_pkg::IdxW-1:0];

endmodule

// ===== rtl/fh64bi_back.sv =====
// fh64bi_back: sequencer that runs the fasthash64 rounds on queued words,
// applies the closing mix and reduces to a bucket index
// depends on fh64bi_pkg, fh64bi_mul and fh64bi_mod
module fh64bi_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  fh64bi_pkg::q_entry_t          q_head,
  output logic                          q_pop,
  input  logic [fh64bi_pkg::HashW-1:0]  seed,
  input  logic [fh64bi_pkg::BcW-1:0]    bucket_div,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fh64bi_pkg::HashW-1:0]  out_hash,
  output logic [fh64bi_pkg::IdxW-1:0]   out_index
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INIT = 7'b0000010,
    S_WMIX = 7'b0000100,
    S_WMUL = 7'b0001000,
    S_FMIX = 7'b0010000,
    S_MOD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic [fh64bi_pkg::HashW-1:0]  h_r, h_nxt;
  logic [fh64bi_pkg::HashW-1:0]  v_r, v_nxt;
  logic                          data_r, data_nxt;
  logic                          last_r, last_nxt;
  logic [fh64bi_pkg::HashW-1:0]  fin_r, fin_nxt;
  logic [fh64bi_pkg::IdxW-1:0]   idx_r, idx_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [fh64bi_pkg::HashW-1:0]  out_hash_r, out_hash_nxt;
  logic [fh64bi_pkg::IdxW-1:0]   out_index_r, out_index_nxt;

  logic                          mul_start;
  logic [fh64bi_pkg::HashW-1:0]  mul_a;
  logic [fh64bi_pkg::HashW-1:0]  mul_b;
  logic                          mul_done;
  logic [fh64bi_pkg::HashW-1:0]  mul_prod;
  logic [fh64bi_pkg::HashW-1:0]  mixed;
  logic [fh64bi_pkg::HashW-1:0]  h_init;
  logic                          mod_start;
  logic                          mod_done;
  logic [fh64bi_pkg::IdxW-1:0]   mod_rem;

  fh64bi_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_prod)
  );

  fh64bi_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mixed),
    .divisor   (bucket_div),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign mixed  = fh64bi_pkg::post_mix(mul_prod);
  assign h_init = seed ^ mul_prod;

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    v_nxt         = v_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    fin_nxt       = fin_r;
    idx_nxt       = idx_r;
    out_hash_nxt  = out_hash_r;
    out_index_nxt = out_index_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    q_pop         = 1'b0;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = fh64bi_pkg::HashM;
    mod_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          v_nxt    = q_head.word;
          data_nxt = q_head.has_data;
          last_nxt = q_head.last;
          if (q_head.first) begin
            mul_start = 1'b1;
            mul_a     = {{(fh64bi_pkg::HashW - fh64bi_pkg::LenBits){1'b0}}, q_head.len};
            mul_b     = fh64bi_pkg::HashM;
            state_nxt = S_INIT;
          end else if (q_head.has_data) begin
            mul_start = 1'b1;
            mul_a     = fh64bi_pkg::pre_mix(q_head.word);
            mul_b     = fh64bi_pkg::MixMul;
            state_nxt = S_WMIX;
          end else if (q_head.last) begin
            mul_start = 1'b1;
            mul_a     = fh64bi_pkg::pre_mix(h_r);
            mul_b     = fh64bi_pkg::MixMul;
            state_nxt = S_FMIX;
          end
        end
      end
      S_INIT: begin
        if (mul_done) begin
          h_nxt = h_init;
          if (data_r) begin
            mul_start = 1'b1;
            mul_a     = fh64bi_pkg::pre_mix(v_r);
            mul_b     = fh64bi_pkg::MixMul;
            state_nxt = S_WMIX;
          end else if (last_r) begin
            mul_start = 1'b1;
            mul_a     = fh64bi_pkg::pre_mix(h_init);
            mul_b     = fh64bi_pkg::MixMul;
            state_nxt = S_FMIX;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WMIX: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = h_r ^ mixed;
          mul_b     = fh64bi_pkg::HashM;
          state_nxt = S_WMUL;
        end
      end
      S_WMUL: begin
        if (mul_done) begin
          h_nxt = mul_prod;
          if (last_r) begin
            mul_start = 1'b1;
            mul_a     = fh64bi_pkg::pre_mix(mul_prod);
            mul_b     = fh64bi_pkg::MixMul;
            state_nxt = S_FMIX;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FMIX: begin
        if (mul_done) begin
          fin_nxt = mixed;
          if (bucket_div == '0) begin
            idx_nxt   = '0;
            state_nxt = S_OUT;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = fin_r;
          out_index_nxt = idx_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= '0;
      data_r      <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      data_r      <= data_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    fin_r       <= fin_nxt;
    idx_r       <= idx_nxt;
    out_hash_r  <= out_hash_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_hash  = out_hash_r;
  assign out_index = out_index_r;

endmodule

// ===== rtl/fasthash64_bucket_index_core.sv =====
// fasthash64_bucket_index_core: top level of the fasthash64 bucket index core
// holds the configuration registers and joins fh64bi_front to fh64bi_back
// depends on fh64bi_pkg, fh64bi_front and fh64bi_back
//
// Streams a key as little-endian 64-bit words and returns its fasthash64 value
// together with the hash modulo the bucket count. Each word with data takes a
// mix product and a product by the hash constant; the opening word first takes
// a length product, the closing word a final mix product and the remainder. All
// products share one 64-bit multiplier; the remainder unit retires 2 bits per cycle.
// A two-entry queue sits behind the input, and a result waits in an output
// register while the next words are taken. Words that arrive outside a key are
// dropped. Write the seed and the bucket count only while no key is in flight.
module fasthash64_bucket_index_core (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: key_length[31:0], key_word[95:32], byte_count[99:96], zero pad
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,
  // in_tuser: first_word
  input  logic         in_tuser,
  input  logic         in_tlast,
  // out_tdata: hash_value[63:0], bucket_index[83:64], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [87:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [63:0]  cfg_data
);

  logic [fh64bi_pkg::HashW-1:0] seed_r;
  logic [fh64bi_pkg::BcW-1:0]   nbuckets_r;
  logic [fh64bi_pkg::BcW-1:0]   bucket_div;
  logic                         cfg_write;
  logic                         q_valid;
  logic                         q_pop;
  fh64bi_pkg::q_entry_t         q_head;
  logic [fh64bi_pkg::HashW-1:0] res_hash;
  logic [fh64bi_pkg::IdxW-1:0]  res_index;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r     <= fh64bi_pkg::SeedReset;
      nbuckets_r <= fh64bi_pkg::BucketReset;
    end else if (cfg_write) begin
      case (fh64bi_pkg::cfg_index_t'(cfg_index))
        fh64bi_pkg::CFG_SEED: begin
          seed_r <= cfg_data;
        end
        fh64bi_pkg::CFG_NBUCKETS: begin
          nbuckets_r <= cfg_data[fh64bi_pkg::BcW-1:0];
        end
        default: begin
          seed_r <= seed_r;
        end
      endcase
    end
  end

  assign bucket_div = (nbuckets_r > fh64bi_pkg::BucketMax) ?
                      fh64bi_pkg::BucketMax : nbuckets_r;

  fh64bi_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .first_word (in_tuser),
    .key_length (in_tdata[31:0]),
    .key_word   (in_tdata[95:32]),
    .byte_count (in_tdata[99:96]),
    .last_word  (in_tlast),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  fh64bi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .seed       (seed_r),
    .bucket_div (bucket_div),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_hash   (res_hash),
    .out_index  (res_index)
  );

  assign out_tdata = {4'h0, res_index, res_hash};

endmodule
